FILE: rtl/core/lphash_pkg.sv
// ----------------------------------------------------------------------------
// lphash_pkg
// Shared types and constants for the linear-probe hash table: item
// structs, operation and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package lphash_pkg;

    // Fixed field widths of the item interface.
    localparam int KEY_BITS   = 31;
    localparam int VALUE_IN   = 32;
    localparam int SLOT_BITS  = 5;
    localparam int COUNT_BITS = 6;

    // The home slot of a table whose size is not a power of two takes two
    // hashing steps: a reciprocal multiply, then a multiply and subtract.
    localparam int HASH_STEPS = 2;
    localparam int HCNT_BITS  = $clog2(HASH_STEPS + 1);

    // Operation codes.
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [KEY_BITS-1:0]   item_key;
        logic [VALUE_IN-1:0]   item_value;
    } t_in_item;

    typedef struct packed {
        logic                  status;
        logic [SLOT_BITS-1:0]  slot_index;
        logic [COUNT_BITS-1:0] used_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic hash_step;
        logic probe_start;
        logic probe_step;
        logic commit;
        logic fail;
        logic out_load;
    } t_ctrl_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clear_last;
        logic hash_done;
        logic hit;
        logic miss_last;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/core/lphash_ctrl.sv
// ----------------------------------------------------------------------------
// lphash_ctrl
// Sequencer for the hash table: clearing pass, item intake, hashing,
// probing and result hand-off.
// ----------------------------------------------------------------------------
module lphash_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lphash_pkg::t_dp_status i_status,
    output lphash_pkg::t_ctrl_cmd  o_cmd
);
    import lphash_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_PROBE  = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HASH;
                end
            end
            S_HASH: begin
                if (i_status.hash_done) begin
                    o_cmd.probe_start = 1'b1;
                    n_state           = S_PROBE;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_PROBE: begin
                o_cmd.probe_step = 1'b1;
                priority if (i_status.hit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_REPORT;
                end else if (i_status.miss_last) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_REPORT;
                end
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: rtl/core/lphash_dp.sv
// ----------------------------------------------------------------------------
// lphash_dp
// Datapath: slot memory, reciprocal home-slot remainder, probe address and
// counters, occupancy count, result and output registers.
// ----------------------------------------------------------------------------
module lphash_dp #(
    parameter int TABLE_SIZE = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lphash_pkg::t_ctrl_cmd  i_cmd,
    output lphash_pkg::t_dp_status o_status,
    input  lphash_pkg::t_in_item   i_in_data,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output lphash_pkg::t_out_item  o_out_data
);
    import lphash_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam bit POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0] SLOT_TOTAL = CW'(TABLE_SIZE);

    // Reciprocal of the table size, rounded up, scaled so that the quotient
    // of any key comes out exact after a right shift.
    localparam int SHIFT = KEY_BITS + AW;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [KEY_BITS:0] RECIP = RECIP_WIDE[KEY_BITS:0];

    // Memory entry: valid mark on top, value below.
    logic [VALUE_BITS:0]   r_mem [TABLE_SIZE];
    logic [VALUE_BITS:0]   r_rd_data;

    logic [AW-1:0]         r_clr_addr;
    logic                  r_func;
    logic [VALUE_BITS-1:0] r_val;
    logic [KEY_BITS-1:0]   r_key;
    logic [KEY_BITS-1:0]   r_quo;
    logic [AW-1:0]         r_rem;
    logic [HCNT_BITS-1:0]  r_hcnt;
    logic [AW-1:0]         r_addr;
    logic [CW-1:0]         r_issue_left;
    logic [CW-1:0]         r_eval_left;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_addr;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_out_vld;

    logic                  issue;
    logic                  match;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS:0]   wr_data;
    logic [63:0]           val_ext;
    logic [2*KEY_BITS:0]   recip_prod;
    logic [KEY_BITS-1:0]   quo_mul;
    logic [KEY_BITS-1:0]   rem_full;
    logic [31:0]           slot_ext;
    logic [31:0]           cnt_ext;

    assign val_ext = 64'(i_in_data.item_value);

    // First hashing step forms the quotient, the second the remainder.
    assign recip_prod = {{(KEY_BITS+1){1'b0}}, r_key} * {{KEY_BITS{1'b0}}, RECIP};
    assign quo_mul    = r_quo * KEY_BITS'(TABLE_SIZE);
    assign rem_full   = r_key - quo_mul;

    assign issue = i_cmd.probe_step && (r_issue_left != '0);
    assign match = (r_func == FUNC_ADD) ? !r_rd_data[VALUE_BITS]
                 : (r_rd_data[VALUE_BITS] && (r_rd_data[VALUE_BITS-1:0] == r_val));

    assign o_status.clear_last = (r_clr_addr == LAST_ADDR);
    assign o_status.hash_done  = (r_hcnt == '0);
    assign o_status.hit        = r_rd_vld && match;
    assign o_status.miss_last  = r_rd_vld && !match && (r_eval_left == CW'(1));
    assign o_status.out_free   = !r_out_vld || i_out_ready;

    always_comb begin
        n_count = r_count;
        if (i_cmd.commit) begin
            n_count = (r_func == FUNC_ADD) ? (r_count + CW'(1)) : (r_count - CW'(1));
        end
    end

    always_comb begin
        wr_en   = i_cmd.clear_step || i_cmd.commit;
        wr_addr = i_cmd.clear_step ? r_clr_addr : r_rd_addr;
        wr_data = '0;
        if (i_cmd.commit && (r_func == FUNC_ADD)) begin
            wr_data = {1'b1, r_val};
        end
    end

    assign slot_ext  = 32'(r_rd_addr);
    assign cnt_ext   = 32'(n_count);

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_count    <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= (r_clr_addr == LAST_ADDR) ? '0 : (r_clr_addr + AW'(1));
            end
            r_count <= n_count;
            if (i_cmd.probe_start) begin
                r_rd_vld <= 1'b0;
            end else begin
                r_rd_vld <= issue;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_in_data.func;
            r_val  <= val_ext[VALUE_BITS-1:0];
            r_key  <= i_in_data.item_key;
            if (POW2) begin
                r_rem  <= i_in_data.item_key[AW-1:0];
                r_hcnt <= '0;
            end else begin
                r_rem  <= '0;
                r_hcnt <= HCNT_BITS'(HASH_STEPS);
            end
        end else if (i_cmd.hash_step) begin
            r_quo  <= KEY_BITS'(recip_prod >> SHIFT);
            r_rem  <= rem_full[AW-1:0];
            r_hcnt <= r_hcnt - HCNT_BITS'(1);
        end

        if (i_cmd.probe_start) begin
            r_addr       <= r_rem;
            r_issue_left <= SLOT_TOTAL;
            r_eval_left  <= SLOT_TOTAL;
        end else begin
            if (issue) begin
                r_addr       <= (r_addr == LAST_ADDR) ? '0 : (r_addr + AW'(1));
                r_issue_left <= r_issue_left - CW'(1);
                r_rd_addr    <= r_addr;
            end
            if (r_rd_vld) begin
                r_eval_left <= r_eval_left - CW'(1);
            end
        end

        if (i_cmd.commit) begin
            r_res.status     <= STATUS_OK;
            r_res.slot_index <= slot_ext[SLOT_BITS-1:0];
            r_res.used_count <= cnt_ext[COUNT_BITS-1:0];
        end else if (i_cmd.fail) begin
            r_res.status     <= STATUS_FAIL;
            r_res.slot_index <= '0;
            r_res.used_count <= cnt_ext[COUNT_BITS-1:0];
        end

        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table of key/value slots with linear probing,
// add-pair and remove-by-value operations, one result per item.
// ----------------------------------------------------------------------------
// After reset the block clears every slot of the slot memory
// and holds o_in_ready low during that pass. It then works on one item at a
// time. An add takes the home slot as key modulo TABLE_SIZE and walks upward
// with wrap-around to the first empty slot; a remove starts at the same home
// slot and walks the whole table for the first used slot holding the given
// value, which it frees (the key is not compared). Each item yields exactly
// one result: status, the slot written or freed (zero on failure), and the
// number of occupied slots afterward. Each item probes k slots, where k
// is 1 to TABLE_SIZE; the slot memory's single read port, one slot per
// cycle, sets the probing time, and the next item is accepted only once
// the output register is free to take the result. When TABLE_SIZE is not
// a power of two, the home slot comes from a reciprocal multiplication
// followed by a multiply and subtract.
// A finished result waits in an output register, so the next item can be
// accepted while the previous result is still waiting to be taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int TABLE_SIZE = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lphash_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lphash_pkg::t_out_item o_out_data
);
    import lphash_pkg::*;

    // Command and status bundles between the sequencer and the datapath.
    t_ctrl_cmd  cmd;
    t_dp_status status;

    // The controller steps through clearing, intake, hashing, probing and
    // result hand-off; it owns the input handshake.
    lphash_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the slot memory, counters and the output register;
    // it owns the output handshake.
    lphash_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for linear_probe_hash_table. A shadow copy of the slot
// table predicts the result of every accepted add and remove. Results are
// checked field by field, in order, while both handshakes idle and stall at
// random. The stimulus covers directed corner cases, filling the table,
// a long output hold-off, and random traffic.
// ----------------------------------------------------------------------------
module testbench;
    import lphash_pkg::*;

    localparam int TABLE_SLOTS = 32;
    localparam int VALUE_WIDTH = 32;
    // Worst case for one item is a probe of every slot plus the overhead of
    // hashing and hand-off. Waiting a bit longer than that covers the tail of the run.
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 16;
    localparam int RANDOM_PHASE_OPS = 120;
    localparam int HOLDOFF_CYCLES = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    linear_probe_hash_table #(
        .TABLE_SIZE(TABLE_SLOTS),
        .VALUE_BITS(VALUE_WIDTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table. Only the occupancy marks and the stored
    // values matter: the key just picks the slot where probing starts.
    bit                   table_used [TABLE_SLOTS];
    logic [VALUE_WIDTH-1:0] table_value [TABLE_SLOTS];
    int unsigned          table_count = 0;

    // Results predicted for accepted items, oldest first.
    t_out_item awaited_results[$];
    t_out_item oldest_result;
    int        mismatch_count = 0;

    // Idling controls. The sender skips a cycle with probability
    // sender_idle_pct percent, and the receiver drops ready with
    // probability receiver_stall_pct percent.
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    // A hold-off request is passed to the receiver process by toggling
    // holdoff_req. The receiver copies the length and counts it down itself.
    bit          holdoff_req = 1'b0;
    bit          holdoff_ack = 1'b0;
    int unsigned holdoff_len = 0;
    int unsigned holdoff_left = 0;

    // Apply one operation to the shadow table and return the result that
    // the block must produce for it. An add takes the first free slot at or
    // after the home slot, wrapping around. A remove takes the first used
    // slot holding the value, searching from the home slot over the whole
    // table. A failure leaves the table untouched and reports slot zero.
    function automatic t_out_item apply_table_op(input t_in_item op);
        t_out_item   res;
        int unsigned probe;
        bit          found;
        res = '0;
        found = 1'b0;
        probe = op.item_key % TABLE_SLOTS;
        for (int n = 0; n < TABLE_SLOTS && !found; n++) begin
            if (op.func == FUNC_ADD) begin
                if (!table_used[probe]) begin
                    table_used[probe] = 1'b1;
                    table_value[probe] = op.item_value;
                    table_count++;
                    found = 1'b1;
                end
            end else if (table_used[probe] && table_value[probe] == op.item_value) begin
                table_used[probe] = 1'b0;
                table_count--;
                found = 1'b1;
            end
            if (!found) begin
                probe = (probe + 1) % TABLE_SLOTS;
            end
        end
        res.status = found ? STATUS_OK : STATUS_FAIL;
        res.slot_index = found ? probe[SLOT_BITS-1:0] : '0;
        res.used_count = table_count[COUNT_BITS-1:0];
        return res;
    endfunction

    // Pick a value that currently sits in the table, so that random removes
    // mostly succeed. Falls back to a random word when the table is empty.
    function automatic logic [VALUE_WIDTH-1:0] stored_value();
        int unsigned start;
        start = $urandom_range(TABLE_SLOTS - 1);
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (table_used[(start + n) % TABLE_SLOTS]) begin
                return table_value[(start + n) % TABLE_SLOTS];
            end
        end
        return $urandom;
    endfunction

    // Offer one item. The task is entered just after a rising edge. It may
    // first idle the input for a random number of cycles, then holds the
    // item until it is accepted. Valid is left high on return so that a
    // following item can go out back to back; the prediction is made at the
    // edge of acceptance.
    task automatic offer_op(input logic func, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_IN-1:0] value);
        t_in_item    op;
        int unsigned gap;
        op.func = func;
        op.item_key = key;
        op.item_value = value;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= op;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        awaited_results.push_back(apply_table_op(op));
    endtask

    // Stop offering and wait until every predicted result has been taken,
    // then let the block settle. The global watchdog bounds this wait.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver side: ready is redrawn every cycle, except during a hold-off,
    // when it stays low for the requested number of cycles.
    always @(posedge i_clk) begin
        if (holdoff_req != holdoff_ack) begin
            holdoff_ack = holdoff_req;
            holdoff_left = holdoff_len;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Every result taken at an edge is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: status %0d slot %0d count %0d",
                         $time, o_out_data.status, o_out_data.slot_index,
                         o_out_data.used_count);
            end else begin
                oldest_result = awaited_results.pop_front();
                if (o_out_data.status !== oldest_result.status) begin
                    mismatch_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, oldest_result.status, o_out_data.status);
                end
                if (o_out_data.slot_index !== oldest_result.slot_index) begin
                    mismatch_count++;
                    $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                             $time, oldest_result.slot_index, o_out_data.slot_index);
                end
                if (o_out_data.used_count !== oldest_result.used_count) begin
                    mismatch_count++;
                    $display("%0t: used_count mismatch: expected %0d, actual %0d",
                             $time, oldest_result.used_count, o_out_data.used_count);
                end
            end
        end
    end

    // Hand-picked cases, starting from the empty table and leaving it empty
    // again: removes from an empty table, key extremes, collisions that wrap
    // past the last slot on add and on remove, duplicate values, a remove
    // whose key points elsewhere than the stored pair, and stale data in a
    // freed slot that must not match.
    task automatic test_directed_cases();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        offer_op(FUNC_REMOVE, 31'd0, 32'd0);
        offer_op(FUNC_ADD, 31'd0, 32'd0);
        offer_op(FUNC_ADD, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        offer_op(FUNC_ADD, 31'd31, 32'd5);
        offer_op(FUNC_ADD, 31'd32, 32'd5);
        offer_op(FUNC_REMOVE, 31'd31, 32'd5);
        offer_op(FUNC_REMOVE, 31'd0, 32'd5);
        offer_op(FUNC_REMOVE, 31'd7, 32'd5);
        offer_op(FUNC_REMOVE, 31'd12345, 32'd0);
        offer_op(FUNC_ADD, 31'h5555_5555, 32'hAAAA_AAAA);
        offer_op(FUNC_ADD, 31'h2AAA_AAAA, 32'h5555_5555);
        offer_op(FUNC_REMOVE, 31'd21, 32'hAAAA_AAAA);
        offer_op(FUNC_ADD, 31'd1, 32'h8000_0000);
        offer_op(FUNC_ADD, 31'd1, 32'h8000_0000);
        offer_op(FUNC_REMOVE, 31'd3, 32'h8000_0000);
        offer_op(FUNC_REMOVE, 31'd2, 32'h8000_0000);
        offer_op(FUNC_REMOVE, 31'd0, 32'hFFFF_FFFF);
        offer_op(FUNC_REMOVE, 31'd0, 32'h5555_5555);
        offer_op(FUNC_REMOVE, 31'd0, 32'd0);
        wait_for_results();
    endtask

    // Fill every slot, try two adds into the full table, then free about
    // half of the entries again.
    task automatic test_table_full();
        sender_idle_pct = 20;
        receiver_stall_pct = 20;
        while (table_count < TABLE_SLOTS) begin
            offer_op(FUNC_ADD, 31'($urandom), $urandom);
        end
        offer_op(FUNC_ADD, 31'h7FFF_FFFF, $urandom);
        offer_op(FUNC_ADD, 31'($urandom), $urandom);
        repeat (TABLE_SLOTS / 2) begin
            offer_op(FUNC_REMOVE, 31'($urandom), stored_value());
        end
        wait_for_results();
    endtask

    // Hold the output side off for a long stretch while items keep coming,
    // so that the output register fills and the input stalls. Afterward the
    // sender waits until every result has drained.
    task automatic test_receiver_holdoff();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        holdoff_len = HOLDOFF_CYCLES;
        holdoff_req = !holdoff_req;
        repeat (16) begin
            offer_op(1'($urandom_range(1)), 31'($urandom_range(63)),
                     32'($urandom_range(7)));
        end
        wait_for_results();
    endtask

    // Random adds and removes. Removes mostly name a value that is stored,
    // keys often collide, and values repeat from a small pool so that
    // duplicates are common. The add rate falls as the table fills, so the
    // occupancy wanders over the whole range and now and then hits full.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        logic                 func;
        logic [KEY_BITS-1:0]  key;
        logic [VALUE_IN-1:0]  value;
        int unsigned          add_pct;
        int unsigned          pick;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (RANDOM_PHASE_OPS) begin
            if (table_count >= TABLE_SLOTS) begin
                add_pct = 20;
            end else if (table_count <= 4) begin
                add_pct = 75;
            end else begin
                add_pct = 55;
            end
            func = ($urandom_range(99) < add_pct) ? FUNC_ADD : FUNC_REMOVE;
            pick = $urandom_range(99);
            if (pick < 20) begin
                key = 31'($urandom_range(63));
            end else if (pick < 30) begin
                key = {26'h3FF_FFFF, 5'($urandom_range(31))};
            end else begin
                key = 31'($urandom);
            end
            pick = $urandom_range(99);
            if (func == FUNC_ADD) begin
                value = (pick < 25) ? 32'($urandom_range(7)) : 32'($urandom);
            end else if (pick < 65) begin
                value = stored_value();
            end else if (pick < 80) begin
                value = 32'($urandom_range(7));
            end else begin
                value = 32'($urandom);
            end
            offer_op(func, key, value);
        end
        wait_for_results();
    endtask

    // Reset is held low at the start. The block then clears its slot memory
    // with its input not ready; the first handshake simply waits for it.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_table_full();
        test_receiver_holdoff();
        test_random_traffic(0, 0);
        test_random_traffic(54, 0);
        test_random_traffic(0, 54);
        test_random_traffic(38, 38);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
